// File: src/track_detection_iou_cost_defines.svh
// Assertion macros used by the checker file tdic_checker.
`ifndef TRACK_DETECTION_IOU_COST_DEFINES_SVH
`define TRACK_DETECTION_IOU_COST_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TDIC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdic: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TDIC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdic: next-cycle check failed");

`endif

// File: src/tdic_pkg.sv
package tdic_pkg;

    // Fixed point of the box coordinates
    localparam int COORD_FRAC_BITS    = 4;
    localparam int COST_FRAC_BITS_DEF = 16;

    // Field widths
    localparam int CRD_W  = 20;
    localparam int AREA_W = 32;
    localparam int ASP_W  = 24;
    localparam int FR_W   = 8;

    // Width from area times aspect
    localparam int PROD_W  = AREA_W + ASP_W;
    localparam int RAD_SHR = 24 - 2 * COORD_FRAC_BITS;
    localparam int RAD_W   = PROD_W - RAD_SHR;
    localparam int W_W     = RAD_W / 2;

    // Height quotient
    localparam int H_NUM_SHL = (2 * COORD_FRAC_BITS >= 8) ? 2 * COORD_FRAC_BITS - 8 : 0;
    localparam int H_DEN_SHL = (2 * COORD_FRAC_BITS >= 8) ? 0 : 8 - 2 * COORD_FRAC_BITS;
    localparam int H_NUM_W   = AREA_W + H_NUM_SHL;
    localparam int H_DEN_W   = W_W + H_DEN_SHL;
    localparam int H_W       = H_NUM_W;

    // Staleness growth: size * (frames + 1) / 1275, rounded half up
    localparam int EXT_DIVISOR = 1275;
    localparam int EXT_HALF    = EXT_DIVISOR / 2;
    localparam int EXT_NUM_W   = H_W + FR_W + 2;

    // Divide by 1275 as multiply by a rounded-up reciprocal and shift; the
    // reciprocal error times any numerator stays below one quotient step
    localparam int EXT_SHR   = EXT_NUM_W + $clog2(EXT_DIVISOR);
    localparam int EXT_REC_W = EXT_NUM_W + 1;
    localparam logic [EXT_REC_W-1:0] EXT_REC_C =
        EXT_REC_W'(((64'd1 << EXT_SHR) + 64'(EXT_DIVISOR - 1)) / 64'(EXT_DIVISOR));
    localparam int EXT_XL_W  = EXT_NUM_W / 2;
    localparam int EXT_XH_W  = EXT_NUM_W - EXT_XL_W;
    localparam int EXT_ML_W  = EXT_XL_W;
    localparam int EXT_MH_W  = EXT_REC_W - EXT_ML_W;
    localparam int EXT_PP_W  = EXT_NUM_W + EXT_REC_W;
    localparam int EXT_Q_W   = EXT_PP_W - EXT_SHR;

    // Doubled-corner geometry
    localparam int GW_W    = W_W + 1;
    localparam int GH_W    = H_W + 1;
    localparam int GEO_W   = (GH_W + 2 > CRD_W + 2) ? GH_W + 2 : CRD_W + 2;
    localparam int SZ_W    = CRD_W + 2;
    localparam int INTER_W = 2 * SZ_W;
    localparam int DAREA_W = 2 * SZ_W;

    // Track area brought to the 4x Q.2F scale
    localparam int S4_SHL = (2 * COORD_FRAC_BITS >= 6) ? 2 * COORD_FRAC_BITS - 6 : 0;
    localparam int S4_SHR = (2 * COORD_FRAC_BITS >= 6) ? 0 : 6 - 2 * COORD_FRAC_BITS;
    localparam int S4_W   = AREA_W + S4_SHL;
    localparam int UNI_MAX = (S4_W > INTER_W)
        ? ((S4_W > DAREA_W + 2) ? S4_W : DAREA_W + 2)
        : ((INTER_W > DAREA_W + 2) ? INTER_W : DAREA_W + 2);
    localparam int UNI_W  = UNI_MAX + 2;

    typedef enum logic {
        OP_PLAIN    = 1'b0,
        OP_EXTENDED = 1'b1
    } opcode_t;

    // One track-detection pair as it travels down the pipe
    typedef struct packed {
        logic                    ext;
        logic signed [CRD_W-1:0] cx;
        logic signed [CRD_W-1:0] cy;
        logic [AREA_W-1:0]       s;
        logic [FR_W-1:0]         fr;
        logic signed [CRD_W-1:0] dl;
        logic signed [CRD_W-1:0] dt;
        logic signed [CRD_W-1:0] dr;
        logic signed [CRD_W-1:0] db;
    } pair_t;

endpackage

// File: src/tdic_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module tdic_sqrt #(
    parameter int RW = 40,
    parameter int PW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [RW-1:0]   in_rad,
    input  logic [PW-1:0]   in_side,
    output logic            out_valid,
    output logic [RW/2-1:0] out_root,
    output logic [PW-1:0]   out_side
);

    localparam int SW = RW / 2;

    logic          v_reg   [0:SW-1];
    logic [RW-1:0] rad_reg [0:SW-1];
    logic [SW-1:0] rt_reg  [0:SW-1];
    logic [SW:0]   rm_reg  [0:SW-1];
    logic [PW-1:0] sd_reg  [0:SW-1];

    genvar i;
    generate
        for (i = 0; i < SW; i++)
        begin : g_stage
            logic          v_in;
            logic [RW-1:0] rad_in;
            logic [SW-1:0] rt_in;
            logic [SW:0]   rm_in;
            logic [PW-1:0] sd_in;
            logic [SW+2:0] cur;
            logic [SW+2:0] trial;
            logic [SW+2:0] diff;
            logic          ge;

            if (i == 0)
            begin : g_first
                assign v_in   = in_valid;
                assign rad_in = in_rad;
                assign rt_in  = '0;
                assign rm_in  = '0;
                assign sd_in  = in_side;
            end
            else
            begin : g_next
                assign v_in   = v_reg[i-1];
                assign rad_in = rad_reg[i-1];
                assign rt_in  = rt_reg[i-1];
                assign rm_in  = rm_reg[i-1];
                assign sd_in  = sd_reg[i-1];
            end

            // Try the next root bit against the two radicand bits brought down
            always_comb
            begin
                cur   = {rm_in, rad_in[RW-1 -: 2]};
                trial = {1'b0, rt_in, 2'b01};
                ge    = (cur >= trial);
                diff  = cur - trial;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i] <= 1'b0;
                else if (en)
                    v_reg[i] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[i] <= rad_in << 2;
                    rt_reg[i]  <= {rt_in[SW-2:0], ge};
                    rm_reg[i]  <= ge ? diff[SW:0] : cur[SW:0];
                    sd_reg[i]  <= sd_in;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[SW-1];
    assign out_root  = rt_reg[SW-1];
    assign out_side  = sd_reg[SW-1];

endmodule

// File: src/tdic_div.sv
// Pipelined restoring integer divider, one quotient bit per stage.
module tdic_div #(
    parameter int NW = 32,
    parameter int DW = 20,
    parameter int PW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic [PW-1:0] in_side,
    output logic          out_valid,
    output logic [NW-1:0] out_quot,
    output logic [PW-1:0] out_side
);

    logic          v_reg  [0:NW-1];
    logic [NW-1:0] nm_reg [0:NW-1];
    logic [DW-1:0] dn_reg [0:NW-1];
    logic [DW-1:0] rm_reg [0:NW-1];
    logic [PW-1:0] sd_reg [0:NW-1];

    genvar i;
    generate
        for (i = 0; i < NW; i++)
        begin : g_stage
            logic          v_in;
            logic [NW-1:0] nm_in;
            logic [DW-1:0] dn_in;
            logic [DW-1:0] rm_in;
            logic [PW-1:0] sd_in;
            logic [DW:0]   t;
            logic [DW:0]   diff;
            logic          ge;

            if (i == 0)
            begin : g_first
                assign v_in  = in_valid;
                assign nm_in = in_num;
                assign dn_in = in_den;
                assign rm_in = '0;
                assign sd_in = in_side;
            end
            else
            begin : g_next
                assign v_in  = v_reg[i-1];
                assign nm_in = nm_reg[i-1];
                assign dn_in = dn_reg[i-1];
                assign rm_in = rm_reg[i-1];
                assign sd_in = sd_reg[i-1];
            end

            // Bring down one numerator bit and subtract if it fits
            always_comb
            begin
                t    = {rm_in, nm_in[NW-1]};
                diff = t - {1'b0, dn_in};
                ge   = (t >= {1'b0, dn_in});
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i] <= 1'b0;
                else if (en)
                    v_reg[i] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    nm_reg[i] <= {nm_in[NW-2:0], ge};
                    dn_reg[i] <= dn_in;
                    rm_reg[i] <= ge ? diff[DW-1:0] : t[DW-1:0];
                    sd_reg[i] <= sd_in;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[NW-1];
    assign out_quot  = nm_reg[NW-1];
    assign out_side  = sd_reg[NW-1];

endmodule

// File: src/tdic_frac.sv
// Pipelined fraction divider: rem/den below one, one fraction bit per stage.
module tdic_frac #(
    parameter int NSTEP = 16,
    parameter int UW    = 48,
    parameter int PW    = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [UW-1:0]    in_rem,
    input  logic [UW-1:0]    in_den,
    input  logic [PW-1:0]    in_side,
    output logic             out_valid,
    output logic [NSTEP-1:0] out_quot,
    output logic [PW-1:0]    out_side
);

    logic             v_reg  [0:NSTEP-1];
    logic [NSTEP-1:0] q_reg  [0:NSTEP-1];
    logic [UW-1:0]    dn_reg [0:NSTEP-1];
    logic [UW-1:0]    rm_reg [0:NSTEP-1];
    logic [PW-1:0]    sd_reg [0:NSTEP-1];

    genvar i;
    generate
        for (i = 0; i < NSTEP; i++)
        begin : g_stage
            logic             v_in;
            logic [NSTEP-1:0] q_in;
            logic [UW-1:0]    dn_in;
            logic [UW-1:0]    rm_in;
            logic [PW-1:0]    sd_in;
            logic [UW-1:0]    t;
            logic             ge;

            if (i == 0)
            begin : g_first
                assign v_in  = in_valid;
                assign q_in  = '0;
                assign dn_in = in_den;
                assign rm_in = in_rem;
                assign sd_in = in_side;
            end
            else
            begin : g_next
                assign v_in  = v_reg[i-1];
                assign q_in  = q_reg[i-1];
                assign dn_in = dn_reg[i-1];
                assign rm_in = rm_reg[i-1];
                assign sd_in = sd_reg[i-1];
            end

            // Double the remainder and subtract the divisor if it fits
            always_comb
            begin
                t  = {rm_in[UW-2:0], 1'b0};
                ge = (t >= dn_in);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i] <= 1'b0;
                else if (en)
                    v_reg[i] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    q_reg[i]  <= {q_in[NSTEP-2:0], ge};
                    dn_reg[i] <= dn_in;
                    rm_reg[i] <= ge ? (t - dn_in) : t;
                    sd_reg[i] <= sd_in;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[NSTEP-1];
    assign out_quot  = q_reg[NSTEP-1];
    assign out_side  = sd_reg[NSTEP-1];

endmodule

// File: src/track_detection_iou_cost.sv
// Track-to-detection IoU cost. Each pair takes a track box (center, area, aspect)
// and a detection box (corners) and returns 1 - IoU in Q1.COST_FRAC_BITS, with
// union_invalid set (and cost at one) when the union is zero or negative. One
// pair is accepted every cycle while the output is not stalled. The pipe holds
// the bit-per-stage square root (20), height divider (32) and IoU fraction
// divider (16) at the default widths; the growth divide by 1275 is a two-stage
// reciprocal multiply. A stall on the output freezes the whole pipe.
module track_detection_iou_cost #(
    parameter int COST_FRAC_BITS = tdic_pkg::COST_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             opcode,
    input  logic signed [tdic_pkg::CRD_W-1:0] track_center_x,
    input  logic signed [tdic_pkg::CRD_W-1:0] track_center_y,
    input  logic [tdic_pkg::AREA_W-1:0]      track_area,
    input  logic [tdic_pkg::ASP_W-1:0]       track_aspect,
    input  logic [tdic_pkg::FR_W-1:0]        frames_since_update,
    input  logic signed [tdic_pkg::CRD_W-1:0] det_left,
    input  logic signed [tdic_pkg::CRD_W-1:0] det_top,
    input  logic signed [tdic_pkg::CRD_W-1:0] det_right,
    input  logic signed [tdic_pkg::CRD_W-1:0] det_bottom,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [COST_FRAC_BITS:0]          cost,
    output logic                             union_invalid
);

    import tdic_pkg::*;

    localparam int SIDE_W = $bits(pair_t);

    logic en;
    logic out_valid_reg;

    // Whole pipe advances whenever the output slot is free or being taken
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // ---------------- capture and area x aspect ----------------
    logic [PROD_W-1:0] prod;
    logic              p1_valid_reg;
    logic [RAD_W-1:0]  p1_rad_reg;
    pair_t             p1_pair_reg;

    assign prod = track_area * track_aspect;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (en)
            p1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_rad_reg     <= prod[PROD_W-1:RAD_SHR];
            p1_pair_reg.ext <= (opcode == OP_EXTENDED);
            p1_pair_reg.cx <= track_center_x;
            p1_pair_reg.cy <= track_center_y;
            p1_pair_reg.s  <= track_area;
            p1_pair_reg.fr <= frames_since_update;
            p1_pair_reg.dl <= det_left;
            p1_pair_reg.dt <= det_top;
            p1_pair_reg.dr <= det_right;
            p1_pair_reg.db <= det_bottom;
        end
    end

    // ---------------- width by square root ----------------
    logic              sq_valid;
    logic [W_W-1:0]    sq_w;
    logic [SIDE_W-1:0] sq_side;
    pair_t             sq_pair;

    tdic_sqrt #(.RW(RAD_W), .PW(SIDE_W)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (p1_valid_reg),
        .in_rad   (p1_rad_reg),
        .in_side  (p1_pair_reg),
        .out_valid(sq_valid),
        .out_root (sq_w),
        .out_side (sq_side)
    );

    assign sq_pair = pair_t'(sq_side);

    // ---------------- height = area / width ----------------
    logic                  dv_valid;
    logic [H_NUM_W-1:0]    dv_q;
    logic [SIDE_W+W_W-1:0] dv_side;
    logic [H_NUM_W-1:0]    h_num;
    logic [H_DEN_W-1:0]    h_den;
    pair_t                 dv_pair;
    logic [W_W-1:0]        dv_w;
    logic [H_W-1:0]        dv_h;

    assign h_num = H_NUM_W'(sq_pair.s) << H_NUM_SHL;
    assign h_den = H_DEN_W'(sq_w) << H_DEN_SHL;

    tdic_div #(.NW(H_NUM_W), .DW(H_DEN_W), .PW(SIDE_W + W_W)) u_hdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (sq_valid),
        .in_num   (h_num),
        .in_den   (h_den),
        .in_side  ({sq_side, sq_w}),
        .out_valid(dv_valid),
        .out_quot (dv_q),
        .out_side (dv_side)
    );

    assign dv_pair = pair_t'(dv_side[SIDE_W+W_W-1:W_W]);
    assign dv_w    = dv_side[W_W-1:0];
    // Zero width means a degenerate box: force the height to zero too
    assign dv_h    = (dv_w == '0) ? '0 : dv_q;

    // ---------------- growth numerators ----------------
    logic [FR_W:0]        fr1;
    logic [W_W+FR_W:0]    ew_prod;
    logic [H_W+FR_W:0]    eh_prod;
    logic                 p2_valid_reg;
    pair_t                p2_pair_reg;
    logic [W_W-1:0]       p2_w_reg;
    logic [H_W-1:0]       p2_h_reg;
    logic [EXT_NUM_W-1:0] p2_ewn_reg;
    logic [EXT_NUM_W-1:0] p2_ehn_reg;

    assign fr1     = {1'b0, dv_pair.fr} + (FR_W + 1)'(1);
    assign ew_prod = dv_w * fr1;
    assign eh_prod = dv_h * fr1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else if (en)
            p2_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_pair_reg <= dv_pair;
            p2_w_reg    <= dv_w;
            p2_h_reg    <= dv_h;
            p2_ewn_reg  <= EXT_NUM_W'(ew_prod) + EXT_NUM_W'(EXT_HALF);
            p2_ehn_reg  <= EXT_NUM_W'(eh_prod) + EXT_NUM_W'(EXT_HALF);
        end
    end

    // ---------------- e1: partial products by the reciprocal of 1275 ----------------
    logic [EXT_ML_W-1:0]          rec_lo;
    logic [EXT_MH_W-1:0]          rec_hi;
    logic                         e1_valid_reg;
    pair_t                        e1_pair_reg;
    logic [W_W-1:0]               e1_w_reg;
    logic [H_W-1:0]               e1_h_reg;
    logic [EXT_XL_W+EXT_ML_W-1:0] e1_ew_ll_reg, e1_eh_ll_reg;
    logic [EXT_XL_W+EXT_MH_W-1:0] e1_ew_lh_reg, e1_eh_lh_reg;
    logic [EXT_XH_W+EXT_ML_W-1:0] e1_ew_hl_reg, e1_eh_hl_reg;
    logic [EXT_XH_W+EXT_MH_W-1:0] e1_ew_hh_reg, e1_eh_hh_reg;

    assign rec_lo = EXT_REC_C[EXT_ML_W-1:0];
    assign rec_hi = EXT_REC_C[EXT_REC_W-1:EXT_ML_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e1_valid_reg <= 1'b0;
        else if (en)
            e1_valid_reg <= p2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_pair_reg  <= p2_pair_reg;
            e1_w_reg     <= p2_w_reg;
            e1_h_reg     <= p2_h_reg;
            e1_ew_ll_reg <= p2_ewn_reg[EXT_XL_W-1:0] * rec_lo;
            e1_ew_lh_reg <= p2_ewn_reg[EXT_XL_W-1:0] * rec_hi;
            e1_ew_hl_reg <= p2_ewn_reg[EXT_NUM_W-1:EXT_XL_W] * rec_lo;
            e1_ew_hh_reg <= p2_ewn_reg[EXT_NUM_W-1:EXT_XL_W] * rec_hi;
            e1_eh_ll_reg <= p2_ehn_reg[EXT_XL_W-1:0] * rec_lo;
            e1_eh_lh_reg <= p2_ehn_reg[EXT_XL_W-1:0] * rec_hi;
            e1_eh_hl_reg <= p2_ehn_reg[EXT_NUM_W-1:EXT_XL_W] * rec_lo;
            e1_eh_hh_reg <= p2_ehn_reg[EXT_NUM_W-1:EXT_XL_W] * rec_hi;
        end
    end

    // ---------------- e2: sum partial products, keep the quotient ----------------
    logic [EXT_PP_W-1:0] ew_sum;
    logic [EXT_PP_W-1:0] eh_sum;
    logic                e2_valid_reg;
    pair_t               e2_pair_reg;
    logic [W_W-1:0]      e2_w_reg;
    logic [H_W-1:0]      e2_h_reg;
    logic [EXT_Q_W-1:0]  e2_ewq_reg;
    logic [EXT_Q_W-1:0]  e2_ehq_reg;

    assign ew_sum = EXT_PP_W'(e1_ew_ll_reg)
                  + (EXT_PP_W'(e1_ew_lh_reg) << EXT_ML_W)
                  + (EXT_PP_W'(e1_ew_hl_reg) << EXT_XL_W)
                  + (EXT_PP_W'(e1_ew_hh_reg) << (EXT_XL_W + EXT_ML_W));
    assign eh_sum = EXT_PP_W'(e1_eh_ll_reg)
                  + (EXT_PP_W'(e1_eh_lh_reg) << EXT_ML_W)
                  + (EXT_PP_W'(e1_eh_hl_reg) << EXT_XL_W)
                  + (EXT_PP_W'(e1_eh_hh_reg) << (EXT_XL_W + EXT_ML_W));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e2_valid_reg <= 1'b0;
        else if (en)
            e2_valid_reg <= e1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e2_pair_reg <= e1_pair_reg;
            e2_w_reg    <= e1_w_reg;
            e2_h_reg    <= e1_h_reg;
            e2_ewq_reg  <= ew_sum[EXT_PP_W-1:EXT_SHR];
            e2_ehq_reg  <= eh_sum[EXT_PP_W-1:EXT_SHR];
        end
    end

    // ---------------- g1: doubled corners ----------------
    logic [GW_W-1:0]          gw;
    logic [GH_W-1:0]          gh;
    logic signed [GEO_W-1:0]  gw_s;
    logic signed [GEO_W-1:0]  gh_s;
    logic signed [GEO_W-1:0]  cx2;
    logic signed [GEO_W-1:0]  cy2;
    logic                     g1_valid_reg;
    logic signed [GEO_W-1:0]  g1_tl_reg, g1_tr_reg, g1_tt_reg, g1_tb_reg;
    logic signed [GEO_W-1:0]  g1_dl_reg, g1_dr_reg, g1_dt_reg, g1_db_reg;
    logic signed [SZ_W-1:0]   g1_dw_reg, g1_dh_reg;
    logic [AREA_W-1:0]        g1_s_reg;

    assign gw   = GW_W'(e2_w_reg) + (e2_pair_reg.ext ? GW_W'(e2_ewq_reg) : '0);
    assign gh   = GH_W'(e2_h_reg) + (e2_pair_reg.ext ? GH_W'(e2_ehq_reg) : '0);
    assign gw_s = signed'(GEO_W'(gw));
    assign gh_s = signed'(GEO_W'(gh));
    assign cx2  = GEO_W'(e2_pair_reg.cx) <<< 1;
    assign cy2  = GEO_W'(e2_pair_reg.cy) <<< 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g1_valid_reg <= 1'b0;
        else if (en)
            g1_valid_reg <= e2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g1_tl_reg <= cx2 - gw_s;
            g1_tr_reg <= cx2 + gw_s;
            g1_tt_reg <= cy2 - gh_s;
            g1_tb_reg <= cy2 + gh_s;
            g1_dl_reg <= GEO_W'(e2_pair_reg.dl) <<< 1;
            g1_dr_reg <= GEO_W'(e2_pair_reg.dr) <<< 1;
            g1_dt_reg <= GEO_W'(e2_pair_reg.dt) <<< 1;
            g1_db_reg <= GEO_W'(e2_pair_reg.db) <<< 1;
            g1_dw_reg <= SZ_W'(e2_pair_reg.dr) - SZ_W'(e2_pair_reg.dl);
            g1_dh_reg <= SZ_W'(e2_pair_reg.db) - SZ_W'(e2_pair_reg.dt);
            g1_s_reg  <= e2_pair_reg.s;
        end
    end

    // ---------------- g2: clamped intersection sides ----------------
    logic signed [GEO_W-1:0] xr, xl, yb, yt;
    logic signed [GEO_W:0]   iw_raw, ih_raw;
    logic                    g2_valid_reg;
    logic [SZ_W-1:0]         g2_iw_reg, g2_ih_reg;
    logic signed [SZ_W-1:0]  g2_dw_reg, g2_dh_reg;
    logic [AREA_W-1:0]       g2_s_reg;

    assign xr     = (g1_tr_reg < g1_dr_reg) ? g1_tr_reg : g1_dr_reg;
    assign xl     = (g1_tl_reg > g1_dl_reg) ? g1_tl_reg : g1_dl_reg;
    assign yb     = (g1_tb_reg < g1_db_reg) ? g1_tb_reg : g1_db_reg;
    assign yt     = (g1_tt_reg > g1_dt_reg) ? g1_tt_reg : g1_dt_reg;
    assign iw_raw = (GEO_W + 1)'(xr) - (GEO_W + 1)'(xl);
    assign ih_raw = (GEO_W + 1)'(yb) - (GEO_W + 1)'(yt);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g2_valid_reg <= 1'b0;
        else if (en)
            g2_valid_reg <= g1_valid_reg;
    end

    // A positive side is bounded by the detection side, so it fits SZ_W
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g2_iw_reg <= (iw_raw > 0) ? iw_raw[SZ_W-1:0] : '0;
            g2_ih_reg <= (ih_raw > 0) ? ih_raw[SZ_W-1:0] : '0;
            g2_dw_reg <= g1_dw_reg;
            g2_dh_reg <= g1_dh_reg;
            g2_s_reg  <= g1_s_reg;
        end
    end

    // ---------------- g3: areas ----------------
    logic                      g3_valid_reg;
    logic [INTER_W-1:0]        g3_inter_reg;
    logic signed [DAREA_W-1:0] g3_darea_reg;
    logic [S4_W-1:0]           g3_s4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g3_valid_reg <= 1'b0;
        else if (en)
            g3_valid_reg <= g2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g3_inter_reg <= g2_iw_reg * g2_ih_reg;
            g3_darea_reg <= g2_dw_reg * g2_dh_reg;
            g3_s4_reg    <= (S4_W'(g2_s_reg) << S4_SHL) >> S4_SHR;
        end
    end

    // ---------------- g4: union ----------------
    logic signed [UNI_W-1:0] s4_s, darea4_s, inter_s;
    logic                    g4_valid_reg;
    logic signed [UNI_W-1:0] g4_uni_reg;
    logic [INTER_W-1:0]      g4_inter_reg;

    assign s4_s     = signed'(UNI_W'(g3_s4_reg));
    assign darea4_s = UNI_W'(g3_darea_reg) <<< 2;
    assign inter_s  = signed'(UNI_W'(g3_inter_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g4_valid_reg <= 1'b0;
        else if (en)
            g4_valid_reg <= g3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g4_uni_reg   <= s4_s + darea4_s - inter_s;
            g4_inter_reg <= g3_inter_reg;
        end
    end

    // ---------------- IoU fraction ----------------
    logic                      uni_bad;
    logic                      iou_full;
    logic [UNI_W-1:0]          fr_rem;
    logic [UNI_W-1:0]          fr_den;
    logic                      fq_valid;
    logic [COST_FRAC_BITS-1:0] fq;
    logic [1:0]                fq_side;

    assign uni_bad  = (g4_uni_reg <= 0);
    assign iou_full = !uni_bad && (signed'(UNI_W'(g4_inter_reg)) >= g4_uni_reg);
    assign fr_rem   = (uni_bad || iou_full) ? '0 : UNI_W'(g4_inter_reg);
    assign fr_den   = uni_bad ? UNI_W'(1) : g4_uni_reg;

    tdic_frac #(.NSTEP(COST_FRAC_BITS), .UW(UNI_W), .PW(2)) u_frac (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (g4_valid_reg),
        .in_rem   (fr_rem),
        .in_den   (fr_den),
        .in_side  ({uni_bad, iou_full}),
        .out_valid(fq_valid),
        .out_quot (fq),
        .out_side (fq_side)
    );

    // ---------------- result register ----------------
    logic [COST_FRAC_BITS:0] one_c;
    logic [COST_FRAC_BITS:0] cost_next;
    logic [COST_FRAC_BITS:0] cost_reg;
    logic                    union_invalid_reg;

    assign one_c = {1'b1, {COST_FRAC_BITS{1'b0}}};

    always_comb
    begin
        if (fq_side[1])
            cost_next = one_c;
        else if (fq_side[0])
            cost_next = '0;
        else
            cost_next = one_c - {1'b0, fq};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= fq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cost_reg          <= cost_next;
            union_invalid_reg <= fq_side[1];
        end
    end

    assign out_valid     = out_valid_reg;
    assign cost          = cost_reg;
    assign union_invalid = union_invalid_reg;

endmodule

// File: src/tdic_checker.sv
`include "track_detection_iou_cost_defines.svh"

module tdic_checker #(
    parameter int COST_FRAC_BITS = tdic_pkg::COST_FRAC_BITS_DEF
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [COST_FRAC_BITS:0] cost,
    input logic                    union_invalid
);

    localparam logic [COST_FRAC_BITS:0] ONE = {1'b1, {COST_FRAC_BITS{1'b0}}};

    // Empty output slot always lets an item in
    `TDIC_ASSERT_IMP(a_idle_ready, !out_valid, in_ready)
    // A stalled result blocks new items
    `TDIC_ASSERT_IMP(a_stall_block, out_valid && !out_ready, !in_ready)
    // Stalled result holds
    `TDIC_ASSERT_NXT(a_hold, out_valid && !out_ready,
                     out_valid && $stable(cost) && $stable(union_invalid))
    // Cost never exceeds one
    `TDIC_ASSERT_IMP(a_cost_range, out_valid, cost <= ONE)
    // Bad union reports no match
    `TDIC_ASSERT_IMP(a_invalid_cost, out_valid && union_invalid, cost == ONE)

endmodule

bind track_detection_iou_cost tdic_checker #(.COST_FRAC_BITS(COST_FRAC_BITS)) u_tdic_checker (.*);

// File: bench/iou_cost_checker.sv
module iou_cost_checker #(
    parameter int COST_FRAC_BITS = tdic_pkg::COST_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic                               opcode,
    input  logic signed [tdic_pkg::CRD_W-1:0]  track_center_x,
    input  logic signed [tdic_pkg::CRD_W-1:0]  track_center_y,
    input  logic [tdic_pkg::AREA_W-1:0]        track_area,
    input  logic [tdic_pkg::ASP_W-1:0]         track_aspect,
    input  logic [tdic_pkg::FR_W-1:0]          frames_since_update,
    input  logic signed [tdic_pkg::CRD_W-1:0]  det_left,
    input  logic signed [tdic_pkg::CRD_W-1:0]  det_top,
    input  logic signed [tdic_pkg::CRD_W-1:0]  det_right,
    input  logic signed [tdic_pkg::CRD_W-1:0]  det_bottom,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [COST_FRAC_BITS:0]            cost,
    input  logic                               union_invalid,
    output int                                 mismatches,
    output int                                 pending
);

    import tdic_pkg::*;

    typedef struct packed {
        logic [COST_FRAC_BITS:0] cost;
        logic                    invalid;
    } iou_result_t;

    iou_result_t expected_costs[$];

    assign pending = expected_costs.size();

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    // Compute cost and union flag for one track-detection pair
    function automatic iou_result_t pair_cost(
        logic ext, longint cx, longint cy, longint unsigned s, longint unsigned r,
        longint unsigned fr, longint dl, longint dt, longint dr, longint db);
        iou_result_t res;
        longint unsigned w, h, ew, eh, q, rem, u;
        longint gw, gh, tl, tr, tt, tb, iw, ih, inter4, darea4, s4, uni;
        w = int_sqrt((s * r) >> (24 - 2 * COORD_FRAC_BITS));
        h = 0;
        if (w != 0)
            h = (s << (2 * COORD_FRAC_BITS - 8)) / w;
        ew = 0;
        eh = 0;
        if (ext)
        begin
            ew = (w * (fr + 1) + EXT_HALF) / EXT_DIVISOR;
            eh = (h * (fr + 1) + EXT_HALF) / EXT_DIVISOR;
        end
        gw = longint'(w + ew);
        gh = longint'(h + eh);
        tl = 2 * cx - gw;
        tr = 2 * cx + gw;
        tt = 2 * cy - gh;
        tb = 2 * cy + gh;
        iw = ((tr < 2 * dr) ? tr : 2 * dr) - ((tl > 2 * dl) ? tl : 2 * dl);
        ih = ((tb < 2 * db) ? tb : 2 * db) - ((tt > 2 * dt) ? tt : 2 * dt);
        if (iw < 0) iw = 0;
        if (ih < 0) ih = 0;
        inter4 = iw * ih;
        darea4 = 4 * ((dr - dl) * (db - dt));
        s4 = longint'(s << (2 * COORD_FRAC_BITS - 6));
        uni = s4 + darea4 - inter4;
        res.invalid = 1'b0;
        if (uni <= 0)
        begin
            res.invalid = 1'b1;
            res.cost = (COST_FRAC_BITS + 1)'(1) << COST_FRAC_BITS;
        end
        else if (inter4 >= uni)
            res.cost = '0;
        else
        begin
            rem = inter4;
            u = uni;
            q = 0;
            for (int i = 0; i < COST_FRAC_BITS; i++)
            begin
                rem <<= 1;
                q <<= 1;
                if (rem >= u)
                begin
                    rem -= u;
                    q |= 1;
                end
            end
            res.cost = (COST_FRAC_BITS + 1)'((64'd1 << COST_FRAC_BITS) - q);
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    initial mismatches = 0;

    // Predict on input items, compare on result items
    always @(posedge clk)
    begin
        iou_result_t want;
        if (rst_n && in_valid && in_ready)
            expected_costs.push_back(pair_cost(opcode, track_center_x, track_center_y,
                track_area, track_aspect, frames_since_update,
                det_left, det_top, det_right, det_bottom));
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_costs.size() == 0)
                report_mismatch("unexpected result, cost", cost, -1);
            else
            begin
                want = expected_costs.pop_front();
                if (cost !== want.cost)
                    report_mismatch("cost", cost, want.cost);
                if (union_invalid !== want.invalid)
                    report_mismatch("union_invalid", union_invalid, want.invalid);
            end
        end
    end

endmodule

// File: bench/tb.sv
module tb;
    import tdic_pkg::*;

    localparam int LATENCY = 77;
    localparam int CYCLE_LIMIT = 400000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    opcode = 1'b0;
    logic signed [CRD_W-1:0] track_center_x = '0;
    logic signed [CRD_W-1:0] track_center_y = '0;
    logic [AREA_W-1:0]       track_area = '0;
    logic [ASP_W-1:0]        track_aspect = '0;
    logic [FR_W-1:0]         frames_since_update = '0;
    logic signed [CRD_W-1:0] det_left = '0;
    logic signed [CRD_W-1:0] det_top = '0;
    logic signed [CRD_W-1:0] det_right = '0;
    logic signed [CRD_W-1:0] det_bottom = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [COST_FRAC_BITS_DEF:0] cost;
    logic                    union_invalid;
    int                      mismatches;
    int                      pending;
    int                      send_idle_pct = 0;
    int                      recv_stall_pct = 0;
    int                      hold_off = 0;
    int                      cycles = 0;
    int                      directed_count = 0;
    int                      random_count = 0;

    always #5 clk = ~clk;

    track_detection_iou_cost dut (.*);

    iou_cost_checker checker_i (.*);

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // Drive out_ready: long hold-off when asked, else random stalls
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one item and hold it until accepted; valid stays up for the next one
    task automatic send_pair(logic op, logic signed [CRD_W-1:0] cx, cy,
        logic [AREA_W-1:0] s, logic [ASP_W-1:0] r, logic [FR_W-1:0] fr,
        logic signed [CRD_W-1:0] dl, dt, dr, db);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        track_center_x <= cx;
        track_center_y <= cy;
        track_area <= s;
        track_aspect <= r;
        frames_since_update <= fr;
        det_left <= dl;
        det_top <= dt;
        det_right <= dr;
        det_bottom <= db;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Random pair: mostly realistic overlapping boxes, some raw noise
    task automatic send_random();
        logic signed [CRD_W-1:0] cx, cy, dl, dt;
        logic [AREA_W-1:0] s;
        logic [ASP_W-1:0] r;
        int dw, dh;
        if ($urandom_range(9) < 2)
            send_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom);
        else
        begin
            cx = $urandom_range(40000) - 20000;
            cy = $urandom_range(40000) - 20000;
            dw = $urandom_range(4000);
            dh = $urandom_range(4000);
            s = (dw * dh) * $urandom_range(1, 32) / 2 + $urandom_range(255);
            r = $urandom_range(1 << 18) + $urandom_range(4096);
            dl = cx - dw / 2 + $urandom_range(400) - 200;
            dt = cy - dh / 2 + $urandom_range(400) - 200;
            send_pair($urandom, cx, cy, s, r, $urandom, dl, dt,
                dl + dw + $urandom_range(50), dt + dh + $urandom_range(50));
        end
        random_count++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: matched box, extremes, degenerate and inverted cases
        send_pair(OP_PLAIN, 0, 0, 32'd25600, 24'h010000, 0, -80, -80, 80, 80);
        send_pair(OP_EXTENDED, 0, 0, 32'd25600, 24'h010000, 8'hFF, -80, -80, 80, 80);
        send_pair(OP_EXTENDED, 100, 100, 32'd25600, 24'h010000, 0, -80, -80, 80, 80);
        send_pair(OP_PLAIN, 0, 0, 32'd0, 24'h010000, 0, 0, 0, 0, 0);
        send_pair(OP_PLAIN, 0, 0, 32'd100, 24'h000000, 0, -10, -10, 10, 10);
        send_pair(OP_PLAIN, 0, 0, 32'd0, 24'd0, 0, 10, 10, -10, -10);
        send_pair(OP_PLAIN, 0, 0, 32'd0, 24'd0, 0, 10, -10, -10, 10);
        send_pair(OP_PLAIN, 5000, 5000, 32'd25600, 24'h010000, 3, -80, -80, 80, 80);
        send_pair(OP_PLAIN, 20'sh7FFFF, 20'sh7FFFF, 32'hFFFFFFFF, 24'hFFFFFF, 8'hFF,
            20'sh80000, 20'sh80000, 20'sh7FFFF, 20'sh7FFFF);
        send_pair(OP_EXTENDED, 20'sh80000, 20'sh80000, 32'hFFFFFFFF, 24'hFFFFFF, 8'hFF,
            20'sh80000, 20'sh80000, 20'sh7FFFF, 20'sh7FFFF);
        send_pair(OP_EXTENDED, 20'sh80000, 20'sh7FFFF, 32'hFFFFFFFF, 24'd1, 8'h80,
            20'sh7FFFF, 20'sh80000, 20'sh80000, 20'sh7FFFF);
        send_pair(OP_PLAIN, 0, 0, 32'h1, 24'hFFFFFF, 0, 0, 0, 1, 1);
        send_pair(OP_EXTENDED, 0, 0, 32'd1000000, 24'h008000, 8'd100, -500, -400, 500, 400);
        send_pair(OP_PLAIN, 0, 0, 32'd100, 24'h010000, 0, 1000, 1000, 1010, 1010);
        directed_count = 14;
        drain();

        // Random phases with different idling
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1) ? 50 : (phase == 3) ? 36 : 0;
            recv_stall_pct = (phase == 2) ? 50 : (phase == 3) ? 36 : 0;
            if (phase == 2)
                hold_off = 300;
            for (int i = 0; i < 100; i++)
                send_random();
            drain();
        end

        repeat (LATENCY + 20) @(posedge clk);
        $display("Ran %0d directed and %0d random pairs, plain and extended,",
            directed_count, random_count);
        $display("under sender gaps, receiver stalls and a long output hold-off.");
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
